// ===== hw/rtl/lab_pkg.sv =====
// ----------------------------------------------------------------------------
// lab_pkg: shared types and constants of the look-at basis block
// Status codes, register indexes and the fixed widths of the unit-vector path.
// ----------------------------------------------------------------------------
package lab_pkg;

  typedef enum logic [2:0] {
    ST_WRITTEN    = 3'd0,
    ST_UNCHANGED  = 3'd1,
    ST_NO_TARGET  = 3'd2,
    ST_ZERO_FWD   = 3'd3,
    ST_ZERO_RIGHT = 3'd4
  } status_t;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X = 2'd0,
    REG_OFFSET_Y = 2'd1,
    REG_OFFSET_Z = 2'd2
  } cfg_reg_t;

  localparam int STATUS_W = 3;
  localparam int UNIT_W   = 16;  // Q1.14 output words
  localparam int NORM_W   = 30;  // normalised magnitude, top bit at 2^29
  localparam int SQ_W     = 64;  // root datapath
  localparam int REM_W    = 48;  // divider remainder
  localparam int UP_W     = 34;  // up-vector product before rounding

endpackage

// ===== hw/rtl/lab_if.sv =====
// ----------------------------------------------------------------------------
// lab_if: channel interfaces of the look-at basis block
// Input item, result item and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lab_in_if #(
  parameter int CW = 32,
  parameter int IW = 16
) ();
  logic                 valid;
  logic                 ready;
  logic                 target_present;
  logic [IW-1:0]        target_id;
  logic signed [CW-1:0] target_x;
  logic signed [CW-1:0] target_y;
  logic signed [CW-1:0] target_z;
  logic [CW-2:0]        target_width;
  logic [CW-2:0]        target_height;
  logic signed [CW-1:0] eye_x;
  logic signed [CW-1:0] eye_y;
  logic signed [CW-1:0] eye_z;

  modport source (output valid, target_present, target_id, target_x, target_y, target_z,
                  target_width, target_height, eye_x, eye_y, eye_z, input ready);
  modport sink (input valid, target_present, target_id, target_x, target_y, target_z,
                target_width, target_height, eye_x, eye_y, eye_z, output ready);
endinterface

interface lab_out_if ();
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [15:0] right_x;
  logic signed [15:0] right_y;
  logic signed [15:0] right_z;
  logic signed [15:0] up_x;
  logic signed [15:0] up_y;
  logic signed [15:0] up_z;
  logic signed [15:0] back_x;
  logic signed [15:0] back_y;
  logic signed [15:0] back_z;

  modport source (output valid, status, right_x, right_y, right_z, up_x, up_y, up_z,
                  back_x, back_y, back_z, input ready);
  modport sink (input valid, status, right_x, right_y, right_z, up_x, up_y, up_z,
                back_x, back_y, back_z, output ready);
endinterface

interface lab_cfg_if #(
  parameter int CW = 32
) ();
  logic          valid;
  logic          ready;
  logic [1:0]    index;
  logic [CW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/look_at_basis.sv =====
// ----------------------------------------------------------------------------
// look_at_basis: look-at basis columns from eye and target
// Front end for key check and forward vector, queue, normalising back end.
// ----------------------------------------------------------------------------
// The block takes one transaction per element: eye position plus the target's
// id, position and size, and returns one result transaction with a status and
// the right, up and back columns in Q1.14. The aim point is target x/y plus
// half the size plus the x/y offsets, with z taken from the z offset alone.
// A transaction whose key (id, target position and size, eye position)
// matches the last stored one returns "unchanged"; no target, an all-zero
// forward and a forward with zero x and z each give their own status with
// zeroed vectors. Writing any offset register drops the stored key; write
// registers only while the block is idle. Path per transaction: short-cut
// statuses pass through the queue and the result register, waiting in the
// queue while the back end is busy or the result waits; a written basis
// goes through the back end, which normalises forward and then right one
// after the other, each through a normalising shift, squaring on one shared
// multiplier, a root at two bits a cycle, a set-up step, a three-lane
// divide and a hand-over step, and then forms up from four short products.
// A two-entry queue lets the front take new transactions while the back
// end is busy or the result waits.
// ----------------------------------------------------------------------------
module look_at_basis #(
  parameter int COORD_WIDTH = 32,
  parameter int ID_WIDTH    = 16
) (
  input  logic      clk,
  input  logic      rst,
  lab_cfg_if.sink   cfg,
  lab_in_if.sink    item,
  lab_out_if.source result
);
  import lab_pkg::*;

  // doubled forward needs three guard bits, one more for the sign
  localparam int DW = COORD_WIDTH + 4;
  localparam int QW = STATUS_W + 3 * DW;

  logic          f_valid, f_ready, b_valid, b_ready;
  logic [QW-1:0] f_data, b_data;

  lab_front #(
    .CW (COORD_WIDTH),
    .IW (ID_WIDTH),
    .DW (DW)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (item),
    .q_valid (f_valid),
    .q_ready (f_ready),
    .q_data  (f_data)
  );

  lab_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  lab_back #(
    .DW (DW)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (b_valid),
    .q_ready (b_ready),
    .q_data  (b_data),
    .result  (result)
  );

endmodule

// ===== hw/rtl/lab_front.sv =====
// ----------------------------------------------------------------------------
// lab_front: accept, key check and forward vector
// Holds the offsets and the last key, forms the doubled forward vector and
// classifies the transaction before it is queued.
// ----------------------------------------------------------------------------
module lab_front #(
  parameter int CW = 32,
  parameter int IW = 16,
  parameter int DW = CW + 4
) (
  input  logic                                clk,
  input  logic                                rst,
  lab_cfg_if.sink                             cfg,
  lab_in_if.sink                              item,
  output logic                                q_valid,
  input  logic                                q_ready,
  output logic [lab_pkg::STATUS_W+3*DW-1:0]   q_data
);
  import lab_pkg::*;

  logic signed [CW-1:0] off_x, off_y, off_z;
  logic                 key_valid;
  logic [IW-1:0]        last_id;
  logic [CW-1:0]        last_tx, last_ty, last_tz, last_ex, last_ey, last_ez;
  logic [CW-2:0]        last_w, last_h;

  logic                 same_key;
  logic                 accept;
  logic signed [DW-1:0] dx, dy, dz;
  status_t              status;

  assign cfg.ready  = 1'b1;
  assign item.ready = q_ready;
  assign q_valid    = item.valid;
  assign accept     = item.valid & q_ready;

  assign same_key = key_valid && item.target_id == last_id &&
                    item.target_x == last_tx && item.target_y == last_ty &&
                    item.target_z == last_tz && item.target_width == last_w &&
                    item.target_height == last_h && item.eye_x == last_ex &&
                    item.eye_y == last_ey && item.eye_z == last_ez;

  // forward at twice the scale keeps the half size exact
  always_comb begin
    dx = (DW'(item.target_x) <<< 1) + $signed(DW'(item.target_width))
       + (DW'(off_x) <<< 1) - (DW'(item.eye_x) <<< 1);
    dy = (DW'(item.target_y) <<< 1) + $signed(DW'(item.target_height))
       + (DW'(off_y) <<< 1) - (DW'(item.eye_y) <<< 1);
    dz = (DW'(off_z) <<< 1) - (DW'(item.eye_z) <<< 1);
    if (!item.target_present) begin
      status = ST_NO_TARGET;
    end else if (same_key) begin
      status = ST_UNCHANGED;
    end else if (dx == '0 && dy == '0 && dz == '0) begin
      status = ST_ZERO_FWD;
    end else if (dx == '0 && dz == '0) begin
      status = ST_ZERO_RIGHT;
    end else begin
      status = ST_WRITTEN;
    end
  end

  assign q_data = {status, dx, dy, dz};

  always_ff @(posedge clk) begin
    if (rst) begin
      off_x     <= '0;
      off_y     <= '0;
      off_z     <= '0;
      key_valid <= 1'b0;
      last_id   <= '0;
      last_tx   <= '0;
      last_ty   <= '0;
      last_tz   <= '0;
      last_w    <= '0;
      last_h    <= '0;
      last_ex   <= '0;
      last_ey   <= '0;
      last_ez   <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_OFFSET_X: off_x <= cfg.data;
          REG_OFFSET_Y: off_y <= cfg.data;
          REG_OFFSET_Z: off_z <= cfg.data;
          default: ;
        endcase
        if (cfg.index inside {REG_OFFSET_X, REG_OFFSET_Y, REG_OFFSET_Z}) begin
          key_valid <= 1'b0;
        end
      end
      if (accept && item.target_present && !same_key) begin
        key_valid <= 1'b1;
        last_id   <= item.target_id;
        last_tx   <= item.target_x;
        last_ty   <= item.target_y;
        last_tz   <= item.target_z;
        last_w    <= item.target_width;
        last_h    <= item.target_height;
        last_ex   <= item.eye_x;
        last_ey   <= item.eye_y;
        last_ez   <= item.eye_z;
      end
    end
  end

endmodule

// ===== hw/rtl/lab_queue.sv =====
// ----------------------------------------------------------------------------
// lab_queue: two-entry queue between front and back
// Plain register FIFO so either side can stall without holding the other.
// ----------------------------------------------------------------------------
module lab_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;
  logic             push, pop;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid & wr_ready;
  assign pop      = rd_valid & rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== hw/rtl/lab_back.sv =====
// ----------------------------------------------------------------------------
// lab_back: normalisation sequencer and result register
// Shift search, sum of squares, root and three divides per vector, run for
// forward then right; up from four short products.
// ----------------------------------------------------------------------------
module lab_back #(
  parameter int DW = 36
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  output logic                               q_ready,
  input  logic [lab_pkg::STATUS_W+3*DW-1:0]  q_data,
  lab_out_if.source                          result
);
  import lab_pkg::*;

  localparam int MW = (DW > NORM_W) ? DW : NORM_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SHIFT, S_SQUARE, S_ROOT, S_PREP, S_DIVIDE, S_NEXT, S_UP
  } state_t;

  state_t                  state;
  logic                    pass;
  logic [3:0]              cnt;
  logic signed [DW-1:0]    d0, d2;
  logic [MW-1:0]           mag [3];
  logic [2:0]              sgn;
  logic [2*NORM_W-1:0]     prod;
  logic [SQ_W-1:0]         acc, rx, rr;
  logic [REM_W-1:0]        rem [3];
  logic [UNIT_W-1:0]       quo [3];
  logic signed [UNIT_W-1:0] f [3];
  logic signed [UNIT_W-1:0] r [3];
  logic signed [2*UNIT_W-1:0] prod_up, pt;

  logic                    out_valid;
  status_t                 out_status;
  logic signed [UNIT_W-1:0] o_rx, o_ry, o_rz, o_ux, o_uy, o_uz, o_bx, o_by, o_bz;

  status_t                 q_status;
  logic signed [DW-1:0]    q_d0, q_d1, q_d2;
  logic [MW-1:0]           mx, sel;
  logic [SQ_W-1:0]         b0, b1, x1, r1, x2, r2;
  logic [3:0]              k0, k1;
  logic [REM_W-1:0]        den;
  logic [REM_W-1:0]        rem_n [3];
  logic [1:0]              qb [3];
  logic signed [UNIT_W-1:0] qs [3];
  logic signed [UNIT_W-1:0] ma, mb;

  function automatic logic [MW-1:0] mag_of(input logic signed [DW-1:0] v);
    mag_of = v[DW-1] ? MW'(-v) : MW'(v);
  endfunction

  function automatic logic [2*SQ_W-1:0] root_step(input logic [SQ_W-1:0] x,
                                                   input logic [SQ_W-1:0] rt,
                                                   input logic [SQ_W-1:0] b);
    logic [SQ_W-1:0] xo, ro;
    if (x >= rt + b) begin
      xo = x - (rt + b);
      ro = (rt >> 1) + b;
    end else begin
      xo = x;
      ro = rt >> 1;
    end
    root_step = {xo, ro};
  endfunction

  // round half up to Q1.14 and saturate
  function automatic logic signed [UNIT_W-1:0] round_q14(input logic signed [UP_W-1:0] p);
    logic signed [UP_W-1:0] t;
    t = (p + UP_W'(8192)) >>> 14;
    if (t > UP_W'(32767)) begin
      round_q14 = 16'sh7fff;
    end else if (t < -UP_W'(32768)) begin
      round_q14 = 16'sh8000;
    end else begin
      round_q14 = t[UNIT_W-1:0];
    end
  endfunction

  assign {q_status, q_d0, q_d1, q_d2} = q_data;
  assign q_ready = state == S_IDLE && !out_valid;

  always_comb begin
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
    case (cnt[1:0])
      2'd0:    sel = mag[0];
      2'd1:    sel = mag[1];
      default: sel = mag[2];
    endcase
    b0 = SQ_W'(1) << (6'd62 - {cnt, 2'b00});
    b1 = b0 >> 2;
    {x1, r1} = root_step(rx, rr, b0);
    {x2, r2} = root_step(x1, r1, b1);
    k0  = 4'd15 - {cnt[2:0], 1'b0};
    k1  = k0 - 4'd1;
    den = REM_W'({rr[NORM_W:0], 1'b0});
    for (int i = 0; i < 3; i++) begin
      rem_n[i] = rem[i];
      qb[i]    = 2'b00;
      if (rem_n[i] >= (den << k0)) begin
        rem_n[i] = rem_n[i] - (den << k0);
        qb[i][1] = 1'b1;
      end
      if (rem_n[i] >= (den << k1)) begin
        rem_n[i] = rem_n[i] - (den << k1);
        qb[i][0] = 1'b1;
      end
      qs[i] = sgn[i] ? -$signed(quo[i]) : $signed(quo[i]);
    end
    case (cnt[1:0])
      2'd0:    begin ma = r[2]; mb = f[1]; end
      2'd1:    begin ma = r[2]; mb = f[0]; end
      2'd2:    begin ma = r[0]; mb = f[2]; end
      default: begin ma = r[0]; mb = f[1]; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cnt       <= '0;
      pass      <= 1'b0;
    end else begin
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            out_status <= q_status;
            if (q_status != ST_WRITTEN) begin
              {o_rx, o_ry, o_rz, o_ux, o_uy, o_uz, o_bx, o_by, o_bz} <= '0;
              out_valid <= 1'b1;
            end else begin
              d0     <= q_d0;
              d2     <= q_d2;
              mag[0] <= mag_of(q_d0);
              mag[1] <= mag_of(q_d1);
              mag[2] <= mag_of(q_d2);
              sgn    <= {q_d2[DW-1], q_d1[DW-1], q_d0[DW-1]};
              pass   <= 1'b0;
              state  <= S_SHIFT;
            end
          end
        end
        S_SHIFT: begin
          cnt <= '0;
          acc <= '0;
          for (int i = 0; i < 3; i++) begin
            if ((mx >> 34) != '0) begin
              mag[i] <= mag[i] >> 4;
            end else if ((mx >> 30) != '0) begin
              mag[i] <= mag[i] >> 1;
            end else if ((mx >> 25) == '0) begin
              mag[i] <= mag[i] << 4;
            end else if ((mx >> 29) == '0) begin
              mag[i] <= mag[i] << 1;
            end
          end
          if ((mx >> 30) == '0 && (mx >> 29) != '0) begin
            state <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          prod <= sel[NORM_W-1:0] * sel[NORM_W-1:0];
          if (cnt != '0) acc <= acc + SQ_W'(prod);
          if (cnt == 4'd3) begin
            rx    <= acc + SQ_W'(prod);
            rr    <= '0;
            cnt   <= '0;
            state <= S_ROOT;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_ROOT: begin
          rx  <= x2;
          rr  <= r2;
          cnt <= cnt + 4'd1;
          if (cnt == 4'd15) state <= S_PREP;
        end
        S_PREP: begin
          for (int i = 0; i < 3; i++) begin
            rem[i] <= (REM_W'(mag[i][NORM_W-1:0]) << 15) + REM_W'(rr[NORM_W:0]);
            quo[i] <= '0;
          end
          cnt   <= '0;
          state <= S_DIVIDE;
        end
        S_DIVIDE: begin
          for (int i = 0; i < 3; i++) begin
            rem[i] <= rem_n[i];
            quo[i] <= {quo[i][UNIT_W-3:0], qb[i]};
          end
          cnt <= cnt + 4'd1;
          if (cnt == 4'd7) state <= S_NEXT;
        end
        S_NEXT: begin
          cnt <= '0;
          if (!pass) begin
            for (int i = 0; i < 3; i++) f[i] <= qs[i];
            // right = (-fz, 0, fx) of the doubled forward
            mag[0] <= mag_of(d2);
            mag[1] <= '0;
            mag[2] <= mag_of(d0);
            sgn    <= {d0[DW-1], 1'b0, !d2[DW-1] && d2 != '0};
            pass   <= 1'b1;
            state  <= S_SHIFT;
          end else begin
            for (int i = 0; i < 3; i++) r[i] <= qs[i];
            state <= S_UP;
          end
        end
        S_UP: begin
          prod_up <= ma * mb;
          cnt     <= cnt + 4'd1;
          case (cnt)
            4'd1: o_ux <= round_q14(-UP_W'(prod_up));
            4'd2: pt <= prod_up;
            4'd3: o_uy <= round_q14(UP_W'(pt) - UP_W'(prod_up));
            4'd4: begin
              o_uz      <= round_q14(UP_W'(prod_up));
              o_rx      <= r[0];
              o_ry      <= r[1];
              o_rz      <= r[2];
              o_bx      <= -f[0];
              o_by      <= -f[1];
              o_bz      <= -f[2];
              out_valid <= 1'b1;
              state     <= S_IDLE;
            end
            default: ;
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid   = out_valid;
  assign result.status  = out_status;
  assign result.right_x = o_rx;
  assign result.right_y = o_ry;
  assign result.right_z = o_rz;
  assign result.up_x    = o_ux;
  assign result.up_y    = o_uy;
  assign result.up_z    = o_uz;
  assign result.back_x  = o_bx;
  assign result.back_y  = o_by;
  assign result.back_z  = o_bz;

endmodule

// ===== hw/rtl/lab_checker.sv =====
// ----------------------------------------------------------------------------
// lab_checker: port-level checks of the look-at basis block
// Result hold under stall and consistency of status with the vectors.
// ----------------------------------------------------------------------------
module lab_checker (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_ready,
  input logic [2:0]         status,
  input logic signed [15:0] right_x,
  input logic signed [15:0] right_y,
  input logic signed [15:0] right_z,
  input logic signed [15:0] up_x,
  input logic signed [15:0] up_y,
  input logic signed [15:0] up_z,
  input logic signed [15:0] back_x,
  input logic signed [15:0] back_y,
  input logic signed [15:0] back_z
);
  import lab_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(status) && $stable(back_x) &&
      $stable(right_x) && $stable(up_y))
    else $error("result changed while stalled");

  a_zero_vec: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != ST_WRITTEN |-> right_x == 0 && right_y == 0 &&
      right_z == 0 && up_x == 0 && up_y == 0 && up_z == 0 && back_x == 0 &&
      back_y == 0 && back_z == 0)
    else $error("vectors not zero on a short-cut status");

  a_back_nz: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_WRITTEN |-> back_x != 0 || back_y != 0 || back_z != 0)
    else $error("written basis with zero back column");

  a_right_flat: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == ST_WRITTEN |-> right_y == 0 && (right_x != 0 || right_z != 0))
    else $error("right column not horizontal");

endmodule

bind look_at_basis lab_checker u_lab_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .status    (result.status),
  .right_x   (result.right_x),
  .right_y   (result.right_y),
  .right_z   (result.right_z),
  .up_x      (result.up_x),
  .up_y      (result.up_y),
  .up_z      (result.up_z),
  .back_x    (result.back_x),
  .back_y    (result.back_y),
  .back_z    (result.back_z)
);

// ===== verif/look_at_basis_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// look_at_basis_test: self-checking bench for the look-at basis block
// Drives eye/target transactions and offset writes, predicts status and basis
// columns in fixed point, and compares every result transaction in order.
// ----------------------------------------------------------------------------

// Holds the offsets and key copy of the block and the queue of expected results.
class basis_scoreboard;
  typedef struct {
    logic [2:0]         status;
    logic signed [15:0] v [9];
  } basis_t;

  logic signed [31:0] off [3];
  bit                 key_valid;
  logic [15:0]        key_id;
  logic [31:0]        key_tp [3];
  logic [30:0]        key_ts [2];
  logic [31:0]        key_ep [3];
  basis_t             pending [$];
  int                 errors;

  function new();
    for (int i = 0; i < 3; i++) off[i] = '0;
    key_valid = 0;
    errors    = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] val);
    if (idx > lab_pkg::REG_OFFSET_Z) return;  // out-of-range index is ignored
    off[idx]  = val;
    key_valid = 0;
  endfunction

  static function longint unsigned int_root(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Unit vector in Q1.14: magnitudes shifted into [2^29, 2^30), floor root.
  static function void unit_vec(input longint d [3], output int q [3]);
    longint unsigned m [3];
    longint unsigned mx, sum, n, r;
    int rs, ls;
    mx = 0; sum = 0; rs = 0; ls = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = d[i] < 0 ? -d[i] : d[i];
      if (m[i] > mx) mx = m[i];
    end
    while ((mx >> rs) >= (64'd1 << 30)) rs++;
    while ((mx << ls) < (64'd1 << 29)) ls++;
    for (int i = 0; i < 3; i++) begin
      m[i] = (m[i] >> rs) << ls;
      sum += m[i] * m[i];
    end
    n = int_root(sum);
    for (int i = 0; i < 3; i++) begin
      r    = ((m[i] << 15) + n) / (2 * n);
      q[i] = d[i] < 0 ? -int'(r) : int'(r);
    end
  endfunction

  static function logic signed [15:0] to_q14(longint p);
    longint t, r;
    t = p + 8192;
    if (t >= 0) r = t / 16384;
    else r = -((-t + 16383) / 16384);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  // Note an accepted input transaction and queue its expected result.
  function void note_input(logic present, logic [15:0] id, logic [31:0] tp [3],
                           logic [30:0] ts [2], logic [31:0] ep [3]);
    basis_t e;
    longint d [3], rv [3];
    int     f [3], r [3];
    e.status = lab_pkg::ST_WRITTEN;
    for (int i = 0; i < 9; i++) e.v[i] = '0;
    if (!present) begin
      e.status = lab_pkg::ST_NO_TARGET;
    end else if (key_valid && id == key_id && tp == key_tp && ts == key_ts && ep == key_ep) begin
      e.status = lab_pkg::ST_UNCHANGED;
    end else begin
      key_valid = 1; key_id = id; key_tp = tp; key_ts = ts; key_ep = ep;
      for (int i = 0; i < 2; i++)
        d[i] = 2 * longint'(signed'(tp[i])) + longint'(ts[i]) + 2 * longint'(off[i])
             - 2 * longint'(signed'(ep[i]));
      d[2] = 2 * longint'(off[2]) - 2 * longint'(signed'(ep[2]));
      if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
        e.status = lab_pkg::ST_ZERO_FWD;
      end else if (d[0] == 0 && d[2] == 0) begin
        e.status = lab_pkg::ST_ZERO_RIGHT;
      end else begin
        unit_vec(d, f);
        rv[0] = -d[2]; rv[1] = 0; rv[2] = d[0];
        unit_vec(rv, r);
        for (int i = 0; i < 3; i++) e.v[i] = r[i][15:0];
        e.v[3] = to_q14(-longint'(r[2]) * f[1]);
        e.v[4] = to_q14(longint'(r[2]) * f[0] - longint'(r[0]) * f[2]);
        e.v[5] = to_q14(longint'(r[0]) * f[1]);
        for (int i = 0; i < 3; i++) e.v[6 + i] = 16'(-f[i]);
      end
    end
    pending.push_back(e);
  endfunction

  function void report(string what);
    errors++;
    $display("ERROR %0t: %s", $time, what);
  endfunction

  // Check one result transaction against the oldest expectation.
  function void check_result(logic [2:0] st, logic signed [15:0] got [9]);
    basis_t e;
    if (pending.size() == 0) begin
      report($sformatf("unexpected result, status %0d", st));
      return;
    end
    e = pending.pop_front();
    if (st !== e.status) report($sformatf("status %0d, expected %0d", st, e.status));
    for (int i = 0; i < 9; i++)
      if (got[i] !== e.v[i])
        report($sformatf("column word %0d is %0d, expected %0d", i, got[i], e.v[i]));
  endfunction
endclass

module look_at_basis_test;
  import lab_pkg::*;

  localparam int LIMIT = 1_500_000;

  logic clk = 0;
  logic rst = 1;
  int   cycles = 0;
  int   send_idle = 31;  // percent of cycles the sender holds off
  int   recv_idle = 83;  // percent of cycles the receiver stalls

  lab_cfg_if #(.CW(32)) cfg ();
  lab_in_if  #(.CW(32), .IW(16)) item ();
  lab_out_if result ();

  basis_scoreboard sb = new();

  look_at_basis #(.COORD_WIDTH(32), .ID_WIDTH(16)) dut (
    .clk(clk), .rst(rst), .cfg(cfg.sink), .item(item.sink),
    .result(result.source)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Watchdog on a cycle count.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random stalls, sampled at the rising edge.
  always @(negedge clk)
    result.ready <= !rst && ($urandom_range(99) >= recv_idle);

  always @(posedge clk)
    if (!rst && result.valid && result.ready)
      sb.check_result(result.status, '{result.right_x, result.right_y, result.right_z,
                                       result.up_x, result.up_y, result.up_z,
                                       result.back_x, result.back_y, result.back_z});

  // Register write: one transaction, idle block only.
  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg.index <= idx;
    cfg.data  <= val;
    cfg.valid <= 1;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg.valid <= 0;
    @(negedge clk);
  endtask

  // Send one input transaction, with a random hold-off beforehand.
  task automatic send(logic present, logic [15:0] id, logic [31:0] tp [3],
                      logic [30:0] ts [2], logic [31:0] ep [3]);
    while ($urandom_range(99) < send_idle) begin
      item.valid <= 0;
      @(negedge clk);
    end
    item.target_present <= present;
    item.target_id      <= id;
    item.target_x       <= tp[0];
    item.target_y       <= tp[1];
    item.target_z       <= tp[2];
    item.target_width   <= ts[0];
    item.target_height  <= ts[1];
    item.eye_x          <= ep[0];
    item.eye_y          <= ep[1];
    item.eye_z          <= ep[2];
    item.valid          <= 1;
    do @(posedge clk); while (!item.ready);
    sb.note_input(present, id, tp, ts, ep);
    @(negedge clk);
  endtask

  // Wait until every expected result is back, then leave the block quiet.
  task automatic drain();
    item.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  // Random coordinate: mostly modest values so aims stay well-conditioned,
  // sometimes the full range and its extremes.
  function automatic logic [31:0] coord();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3: return $urandom;
      default: return $urandom_range(32'h00ff_ffff) - 32'h0080_0000;
    endcase
  endfunction

  task automatic random_items(int count);
    logic [31:0] tp [3], ep [3];
    logic [30:0] ts [2];
    logic [15:0] id;
    logic        present;
    for (int n = 0; n < count; n++) begin
      // Repeat the previous key now and then to exercise the unchanged path.
      if (n == 0 || $urandom_range(5) != 0) begin
        id = 16'($urandom);
        for (int i = 0; i < 3; i++) begin
          tp[i] = coord();
          ep[i] = coord();
        end
        ts[0] = 31'($urandom_range(3) == 0 ? $urandom : $urandom_range(31'hffff_ff));
        ts[1] = 31'($urandom_range(3) == 0 ? $urandom : $urandom_range(31'hffff_ff));
        // Degenerate aims: eye placed exactly on the aim point in x/z or all.
        if ($urandom_range(15) == 0) begin
          ts[0] = 31'({$urandom_range(32'h00ff_ffff), 1'b0});
          ep[0] = tp[0] + (ts[0] >> 1) + sb.off[0];
          ep[2] = sb.off[2];
          if ($urandom_range(1)) begin
            ts[1] = 31'({$urandom_range(32'h00ff_ffff), 1'b0});
            ep[1] = tp[1] + (ts[1] >> 1) + sb.off[1];
          end
        end
      end
      present = ($urandom_range(9) != 0);
      send(present, id, tp, ts, ep);
    end
  endtask

  initial begin
    logic [31:0] tp [3], ep [3];
    logic [30:0] ts [2];
    cfg.valid = 0; cfg.index = REG_OFFSET_X; cfg.data = '0;
    item.valid = 0; item.target_present = 0; item.target_id = '0;
    item.target_x = '0; item.target_y = '0; item.target_z = '0;
    item.target_width = '0; item.target_height = '0;
    item.eye_x = '0; item.eye_y = '0; item.eye_z = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: no target, plain aim, repeated key, zero forward, zero right,
    // field extremes.
    tp = '{32'h0001_0000, 32'h0002_0000, 32'h0};
    ts = '{31'h0002_0000, 31'h0004_0000};
    ep = '{32'h0, 32'h0, 32'hfff0_0000};
    send(0, 16'h0, tp, ts, ep);
    send(1, 16'h1234, tp, ts, ep);
    send(1, 16'h1234, tp, ts, ep);
    send(1, 16'hffff, tp, ts, ep);
    ep = '{32'h0002_0000, 32'h0004_0000, 32'h0};
    send(1, 16'h1, tp, ts, ep);
    ep = '{32'h0002_0000, 32'h0, 32'h0};
    send(1, 16'h2, tp, ts, ep);
    tp = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    ts = '{31'h7fff_ffff, 31'h7fff_ffff};
    ep = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    send(1, 16'h3, tp, ts, ep);
    tp = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    ts = '{31'h0, 31'h0};
    ep = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    send(1, 16'h4, tp, ts, ep);
    ep = '{32'h8000_0000, 32'h0, 32'h7fff_ffff};
    send(1, 16'h4, tp, ts, ep);
    drain();

    // Offsets at extremes; any write clears the key.
    write_reg(REG_OFFSET_X, 32'h7fff_ffff);
    write_reg(REG_OFFSET_Y, 32'h8000_0000);
    write_reg(REG_OFFSET_Z, 32'h7fff_ffff);
    send(1, 16'h4, tp, ts, ep);
    send(1, 16'h4, tp, ts, ep);
    drain();
    write_reg(REG_OFFSET_Z, 32'h8000_0000);
    send(1, 16'h4, tp, ts, ep);
    drain();

    // Random phases under the three idling regimes, offsets changed between.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin send_idle = 83; recv_idle = 31; end
      if (ph == 4) begin send_idle = 0; recv_idle = 0; end
      write_reg(REG_OFFSET_X, ph == 0 ? 32'h0 : $urandom_range(32'h00ff_ffff) - 32'h0080_0000);
      write_reg(REG_OFFSET_Y, ph == 0 ? 32'h0 : $urandom_range(32'h00ff_ffff) - 32'h0080_0000);
      write_reg(REG_OFFSET_Z, ph == 5 ? $urandom : $urandom_range(32'h00ff_ffff) - 32'h0080_0000);
      random_items(320);
      drain();
    end

    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
